/* hw/rtl/splay_tree_prefix_codec_macros.svh */
// Assertion macros shared by the splay-tree prefix codec RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SPLAY_TREE_PREFIX_CODEC_MACROS_SVH
`define SPLAY_TREE_PREFIX_CODEC_MACROS_SVH

// same-cycle implication check
`define STPC_CHECK(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication check
`define STPC_CHECK_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/stpc_pkg.sv */
// Package for the splay-tree prefix codec: word types and job codes.
// No dependencies; imported by every module of the block.
`default_nettype none
package stpc_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       stream_end;
    logic       bad_stream;
    logic       last_of_run;
  } out_word_t;

  // job code = {direction, cmd}
  localparam logic [1:0] OP_CDATA = 2'b00;
  localparam logic [1:0] OP_CEND  = 2'b01;
  localparam logic [1:0] OP_DDATA = 2'b10;
  localparam logic [1:0] OP_DEND  = 2'b11;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } job_t;

  typedef struct packed {
    logic clearing;
  } stat_t;

endpackage
`default_nettype wire

/* hw/rtl/splay_tree_prefix_codec.sv */
// Compress traces the code path up the tree, packs its bits and then splays the leaf, a splay
// step lifting the leaf two levels; decompress walks the tree one code bit at a time.
// The engine codes one word at a time.
// An end word also starts a tree clearing pass over all CONTEXTS*516 tree nodes, as does reset.
// Reset (rst, synchronous, high): direction 0, empty queues, then the clearing pass;
// full stays high while the trees are being cleared.
// Top level of the splay-tree prefix codec.
// Depends on stpc_pkg, stpc_front, stpc_engine, stpc_outq.
`default_nettype none
module splay_tree_prefix_codec import stpc_pkg::*; #(
  parameter int CONTEXTS = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  // input word channel, queue style
  input  wire logic     push,
  output logic          full,
  input  wire in_word_t in_word,
  // result word channel, queue style
  output logic          empty,
  input  wire logic     pop,
  output out_word_t     out_word,
  // direction register write channel
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic     cfg_data
);

  logic      job_valid;
  job_t      job;
  logic      job_pop;
  stat_t     stat;
  logic      oq_push;
  out_word_t oq_word;
  logic      oq_full;

  // front: holds direction and tags each word as a job
  stpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .stat      (stat)
  );

  // back: tree walk, splay and bit packing
  stpc_engine #(
    .CONTEXTS (CONTEXTS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .stat      (stat),
    .oq_push   (oq_push),
    .oq_word   (oq_word),
    .oq_full   (oq_full)
  );

  // result buffering toward the consumer
  stpc_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .wr       (oq_push),
    .wdata    (oq_word),
    .oq_full  (oq_full),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

/* hw/rtl/stpc_front.sv */
// Front end: config register, input word classification and a 2-deep job queue.
// Depends on stpc_pkg.
`default_nettype none
module stpc_front import stpc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire in_word_t in_word,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire logic     cfg_data,
  output logic          job_valid,
  output job_t          job,
  input  wire logic     job_pop,
  input  wire stat_t    stat
);

  logic       direction;
  job_t       q [2];
  logic [1:0] cnt;
  logic       take;
  logic       wr_idx;

  assign cfg_ready = 1'b1;
  assign full      = (cnt == 2'd2) || stat.clearing;
  assign take      = push && !full;
  assign job_valid = (cnt != 2'd0);
  assign job       = q[0];
  // slot for the new word after an optional pop this cycle
  assign wr_idx    = (job_pop ? (cnt == 2'd2) : (cnt != 2'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
      cnt       <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        direction <= cfg_data;
      end
      cnt <= cnt + {1'b0, take} - {1'b0, job_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (take && !wr_idx) begin
      q[0] <= '{op: {direction, in_word.cmd}, data: in_word.in_byte};
    end else if (job_pop) begin
      q[0] <= q[1];
    end
    if (take && wr_idx) begin
      q[1] <= '{op: {direction, in_word.cmd}, data: in_word.in_byte};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/stpc_outq.sv */
// Result queue: 4-entry FIFO of result words between engine and output ports.
// Depends on stpc_pkg.
`default_nettype none
module stpc_outq import stpc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr,
  input  wire out_word_t wdata,
  output logic           oq_full,
  output logic           empty,
  input  wire logic      pop,
  output out_word_t      out_word
);

  out_word_t  mem [4];
  logic [1:0] rp;
  logic [1:0] wp;
  logic [2:0] cnt;
  logic       rd;
  logic       we;

  assign oq_full  = (cnt == 3'd4);
  assign empty    = (cnt == 3'd0);
  assign we       = wr && !oq_full;
  assign rd       = pop && !empty;
  assign out_word = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      rp  <= 2'd0;
      wp  <= 2'd0;
      cnt <= 3'd0;
    end else begin
      if (we) begin
        wp <= wp + 2'd1;
      end
      if (rd) begin
        rp <= rp + 2'd1;
      end
      cnt <= cnt + {2'd0, we} - {2'd0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wp] <= wdata;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/stpc_engine.sv */
// Back end: splay-tree memories, path stack, bit packer and the coding sequencer.
// Depends on stpc_pkg and splay_tree_prefix_codec_macros.svh.
`default_nettype none
`include "splay_tree_prefix_codec_macros.svh"
module stpc_engine import stpc_pkg::*; #(
  parameter int CONTEXTS = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      job_pop,
  output stat_t     stat,
  output logic      oq_push,
  output out_word_t oq_word,
  input  wire logic oq_full
);

  localparam int CW    = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int UP_D  = CONTEXTS * 1024;
  localparam int LR_D  = CONTEXTS * 512;
  localparam int STK_D = 260;

  localparam logic [9:0] LAST_INNER = 10'd257;
  localparam logic [9:0] LEAF_BASE  = 10'd258;
  localparam logic [9:0] LAST_NODE  = 10'd515;
  localparam logic [8:0] END_SYM    = 9'd256;

  // ceil(2^18 / CONTEXTS); exact quotient for every 9-bit symbol
  localparam logic [18:0] CRECIP = 19'((262144 + CONTEXTS - 1) / CONTEXTS);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_ENC1  = 5'd2;
  localparam logic [4:0] S_ENC2  = 5'd3;
  localparam logic [4:0] S_ENC3  = 5'd4;
  localparam logic [4:0] S_PUT   = 5'd5;
  localparam logic [4:0] S_PUT2  = 5'd6;
  localparam logic [4:0] S_SPI   = 5'd7;
  localparam logic [4:0] S_SP1   = 5'd8;
  localparam logic [4:0] S_SP2   = 5'd9;
  localparam logic [4:0] S_SP3   = 5'd10;
  localparam logic [4:0] S_SP4   = 5'd11;
  localparam logic [4:0] S_SP5   = 5'd12;
  localparam logic [4:0] S_SP6   = 5'd13;
  localparam logic [4:0] S_SP7   = 5'd14;
  localparam logic [4:0] S_SP8   = 5'd15;
  localparam logic [4:0] S_SPD   = 5'd16;
  localparam logic [4:0] S_DW1   = 5'd17;
  localparam logic [4:0] S_DW2   = 5'd18;
  localparam logic [4:0] S_DNEXT = 5'd19;
  localparam logic [4:0] S_EMIT  = 5'd20;
  localparam logic [4:0] S_CEND2 = 5'd21;
  localparam logic [4:0] S_FIN   = 5'd22;

  // values stored in the trees stay below 516
  function automatic logic [9:0] m516(input logic [9:0] x);
    return (x > LAST_NODE) ? (x - 10'd516) : x;
  endfunction

  function automatic logic [9:0] m258(input logic [9:0] x);
    return (x > LAST_INNER) ? (x - LEAF_BASE) : x;
  endfunction

  // remainder by CONTEXTS through a reciprocal multiply
  function automatic logic [8:0] cmod(input logic [8:0] s);
    logic [27:0] prod;
    logic [8:0]  q;
    logic [17:0] qc;
    prod = {19'd0, s} * {9'd0, CRECIP};
    q    = prod[26:18];
    qc   = {9'd0, q} * 18'(CONTEXTS);
    return s - qc[8:0];
  endfunction

  // tree memories, indexed {context, node}
  logic [9:0] up_mem [UP_D];
  logic [9:0] lf_mem [LR_D];
  logic [9:0] rt_mem [LR_D];
  logic       stk_mem [STK_D];

  logic [CW+9:0] up_ra, up_wa;
  logic [CW+8:0] lf_ra, lf_wa, rt_ra, rt_wa;
  logic [8:0]    stk_ra, stk_wa;
  logic [9:0]    up_wd, lf_wd, rt_wd;
  logic          up_we, lf_we, rt_we, stk_we, stk_wd;
  logic [9:0]    up_rd, lf_rd, rt_rd;
  logic          stk_rd;

  logic [4:0]    st, ret;
  logic [1:0]    op;
  logic [7:0]    data;
  logic [2:0]    bit_i;
  logic [8:0]    sym;
  logic [9:0]    a, b, c, d, p, walk;
  logic [8:0]    sp;
  logic [CW-1:0] ctx;
  logic [7:0]    pack_bits;
  logic [3:0]    room;
  logic          end_seen;
  logic          clr_after;
  out_word_t     pend, nres;
  logic          pend_v;
  logic [CW-1:0] cl_ctx;
  logic [9:0]    cl_node;

  logic [9:0]    up_rd_m;
  logic [9:0]    walk_m;
  logic [9:0]    wv;
  logic [7:0]    nb;
  logic [8:0]    sym_mod;
  logic          cl_done;

  assign up_rd_m = m258(up_rd);
  assign walk_m  = (m258(walk) == 10'd0) ? 10'd1 : m258(walk);
  assign wv      = data[bit_i] ? rt_rd : lf_rd;
  assign nb      = {stk_rd, pack_bits[7:1]};
  assign sym_mod = cmod(sym);
  assign cl_done = (cl_ctx == CW'(CONTEXTS - 1)) && (cl_node == LAST_NODE);

  assign job_pop       = (st == S_IDLE) && job_valid;
  assign stat.clearing = (st == S_CLR);

  always_comb begin
    oq_word             = pend;
    oq_word.last_of_run = (st == S_FIN);
    oq_push             = ((st == S_EMIT) || (st == S_FIN)) && pend_v && !oq_full;
  end

  // memory port control
  always_comb begin
    up_we  = 1'b0;
    up_wa  = {ctx, a};
    up_wd  = d;
    up_ra  = {ctx, m516(a)};
    lf_we  = 1'b0;
    lf_wa  = {ctx, d[8:0]};
    lf_wd  = a;
    lf_ra  = {ctx, c[8:0]};
    rt_we  = 1'b0;
    rt_wa  = {ctx, d[8:0]};
    rt_wd  = a;
    rt_ra  = {ctx, d[8:0]};
    stk_we = 1'b0;
    stk_wa = sp;
    stk_wd = (rt_rd == a);
    stk_ra = sp - 9'd1;
    case (st)
      S_CLR: begin
        up_we = 1'b1;
        up_wa = {cl_ctx, cl_node};
        up_wd = (cl_node < 10'd2) ? 10'd0 : (cl_node >> 1);
        lf_we = (cl_node <= LAST_INNER);
        rt_we = (cl_node <= LAST_INNER);
        lf_wa = {cl_ctx, cl_node[8:0]};
        rt_wa = {cl_ctx, cl_node[8:0]};
        lf_wd = (cl_node == 10'd0) ? 10'd0 : {cl_node[8:0], 1'b0};
        rt_wd = (cl_node == 10'd0) ? 10'd0 : {cl_node[8:0], 1'b1};
      end
      S_ENC2: rt_ra = {ctx, up_rd_m[8:0]};
      S_ENC3: stk_we = 1'b1;
      S_SP2:  up_ra = {ctx, up_rd};
      S_SP3:  lf_ra = {ctx, up_rd_m[8:0]};
      S_SP4: begin
        lf_we = (c != lf_rd);
      end
      S_SP5: rt_we = 1'b1;
      S_SP7: begin
        up_we = 1'b1;
        lf_wa = {ctx, c[8:0]};
        rt_wa = {ctx, c[8:0]};
        lf_wd = b;
        rt_wd = b;
        lf_we = (a == lf_rd);
        rt_we = (a != lf_rd);
      end
      S_SP8: begin
        up_we = 1'b1;
        up_wa = {ctx, m516(b)};
        up_wd = c;
      end
      S_DW1: begin
        lf_ra = {ctx, walk_m[8:0]};
        rt_ra = {ctx, walk_m[8:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    up_rd  <= up_mem[up_ra];
    lf_rd  <= lf_mem[lf_ra];
    rt_rd  <= rt_mem[rt_ra];
    stk_rd <= stk_mem[stk_ra];
    if (up_we) up_mem[up_wa] <= up_wd;
    if (lf_we) lf_mem[lf_wa] <= lf_wd;
    if (rt_we) rt_mem[rt_wa] <= rt_wd;
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLR;
      cl_ctx    <= '0;
      cl_node   <= 10'd0;
      pend_v    <= 1'b0;
      ctx       <= '0;
      pack_bits <= 8'd0;
      room      <= 4'd8;
      walk      <= 10'd1;
      end_seen  <= 1'b0;
      clr_after <= 1'b0;
      sp        <= 9'd0;
    end else begin
      case (st)
        S_IDLE: begin
          if (job_valid) begin
            op        <= job.op;
            data      <= job.data;
            bit_i     <= 3'd0;
            clr_after <= 1'b0;
            sp        <= 9'd0;
            case (job.op)
              OP_CDATA: begin
                sym <= {1'b0, job.data};
                a   <= {2'b00, job.data} + LEAF_BASE;
                st  <= S_ENC1;
              end
              OP_CEND: begin
                sym <= END_SYM;
                a   <= {1'b0, END_SYM} + LEAF_BASE;
                st  <= S_ENC1;
              end
              OP_DDATA: begin
                if (!end_seen) begin
                  st <= S_DW1;
                end
              end
              OP_DEND: begin
                nres      <= '{8'd0, 1'b0, end_seen, !end_seen, 1'b0};
                ret       <= S_FIN;
                clr_after <= 1'b1;
                st        <= S_EMIT;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          if (cl_done) begin
            st        <= S_IDLE;
            ctx       <= '0;
            pack_bits <= 8'd0;
            room      <= 4'd8;
            walk      <= 10'd1;
            end_seen  <= 1'b0;
          end else if (cl_node == LAST_NODE) begin
            cl_node <= 10'd0;
            cl_ctx  <= cl_ctx + 1'b1;
          end else begin
            cl_node <= cl_node + 10'd1;
          end
        end
        S_ENC1: st <= S_ENC2;
        S_ENC2: begin
          p  <= up_rd_m;
          st <= S_ENC3;
        end
        S_ENC3: begin
          sp <= sp + 9'd1;
          a  <= p;
          if (p != 10'd1 && p != 10'd0 && (sp + 9'd1) < 9'(STK_D)) begin
            st <= S_ENC1;
          end else begin
            st <= S_PUT;
          end
        end
        S_PUT: begin
          if (sp == 9'd0) begin
            st <= S_SPI;
          end else begin
            sp <= sp - 9'd1;
            st <= S_PUT2;
          end
        end
        S_PUT2: begin
          pack_bits <= nb;
          if (room == 4'd1) begin
            room <= 4'd8;
            nres <= '{nb, 1'b1, 1'b0, 1'b0, 1'b0};
            ret  <= S_PUT;
            st   <= S_EMIT;
          end else begin
            room <= room - 4'd1;
            st   <= S_PUT;
          end
        end
        S_SPI: begin
          a  <= m516({1'b0, sym} + LEAF_BASE);
          st <= S_SP1;
        end
        S_SP1: st <= S_SP2;
        S_SP2: begin
          if (up_rd != 10'd1 && up_rd != 10'd0 && up_rd <= LAST_INNER) begin
            c  <= up_rd;
            st <= S_SP3;
          end else begin
            st <= S_SPD;
          end
        end
        S_SP3: begin
          d  <= up_rd_m;
          st <= S_SP4;
        end
        S_SP4: begin
          if (c == lf_rd) begin
            st <= S_SP5;
          end else begin
            b  <= lf_rd;
            st <= S_SP6;
          end
        end
        S_SP5: begin
          b  <= rt_rd;
          st <= S_SP6;
        end
        S_SP6: st <= S_SP7;
        S_SP7: st <= S_SP8;
        S_SP8: begin
          a <= d;
          if (d != 10'd1 && d != 10'd0) begin
            st <= S_SP1;
          end else begin
            st <= S_SPD;
          end
        end
        S_SPD: begin
          ctx <= sym_mod[CW-1:0];
          if (op == OP_DDATA) begin
            if (sym == END_SYM) begin
              end_seen <= 1'b1;
              nres     <= '{8'd0, 1'b0, 1'b1, 1'b0, 1'b0};
            end else begin
              nres <= '{sym[7:0], 1'b1, 1'b0, 1'b0, 1'b0};
            end
            ret <= S_DNEXT;
            st  <= S_EMIT;
          end else if (op == OP_CEND) begin
            nres <= '{8'(pack_bits >> room), 1'b1, 1'b0, 1'b0, 1'b0};
            ret  <= S_CEND2;
            st   <= S_EMIT;
          end else begin
            st <= S_FIN;
          end
        end
        S_CEND2: begin
          nres      <= '{8'd0, 1'b1, 1'b1, 1'b0, 1'b0};
          ret       <= S_FIN;
          clr_after <= 1'b1;
          st        <= S_EMIT;
        end
        S_DW1: st <= S_DW2;
        S_DW2: begin
          if (wv > LAST_INNER) begin
            sym  <= 9'(wv - LEAF_BASE);
            walk <= 10'd1;
            st   <= S_SPI;
          end else begin
            walk <= wv;
            st   <= S_DNEXT;
          end
        end
        S_DNEXT: begin
          if (bit_i == 3'd7 || end_seen) begin
            st <= S_FIN;
          end else begin
            bit_i <= bit_i + 3'd1;
            st    <= S_DW1;
          end
        end
        S_EMIT: begin
          // previous result leaves, the new one is held until we know if it is last
          if (!pend_v || !oq_full) begin
            pend   <= nres;
            pend_v <= 1'b1;
            st     <= ret;
          end
        end
        S_FIN: begin
          if (!pend_v) begin
            if (clr_after) begin
              cl_ctx  <= '0;
              cl_node <= 10'd0;
              st      <= S_CLR;
            end else begin
              st <= S_IDLE;
            end
          end else if (!oq_full) begin
            pend_v <= 1'b0;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  `STPC_CHECK(a_push_room, clk, rst, oq_push, !oq_full, "push into a full result queue")
  `STPC_CHECK(a_idle_flushed, clk, rst, st == S_IDLE, !pend_v, "idle with a held result")
  `STPC_CHECK(a_room_range, clk, rst, 1'b1, room != 4'd0 && room <= 4'd8, "pack room out of range")
  `STPC_CHECK(a_stack_bound, clk, rst, 1'b1, sp <= 9'(STK_D), "path stack overrun")
  `STPC_CHECK_NEXT(a_fin_drain, clk, rst, st == S_FIN && pend_v && !oq_full, !pend_v, "last result not sent")

endmodule
`default_nettype wire
